// File: sv/fdi_pkg.sv
// ----------------------------------------------------------------------------
// Feedback delay package
// Shared types, register indexes, arithmetic constants and the microcode
// program of the interpolating feedback delay.
// ----------------------------------------------------------------------------
package fdi_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd2;

  // Reset value of the wet share and the Q1.15 value of unity.
  localparam logic [15:0] WET_MIX_RESET = 16'd16384;
  localparam logic [15:0] UNITY_Q15     = 16'd32768;

  // One-pole smoothing coefficient, 0.002 in Q0.24.
  localparam int SMOOTH_K = 33554;

  // Widths of the shared multiplier and the accumulator.
  localparam int A_W   = 33;
  localparam int B_W   = 18;
  localparam int ACC_W = A_W + B_W + 1;

  // Program step addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IN   = 4'd0;
  localparam logic [STEP_W-1:0] ST_MULK = 4'd1;
  localparam logic [STEP_W-1:0] ST_SD   = 4'd2;
  localparam logic [STEP_W-1:0] ST_RP   = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD0  = 4'd4;
  localparam logic [STEP_W-1:0] ST_RD1  = 4'd5;
  localparam logic [STEP_W-1:0] ST_INT0 = 4'd6;
  localparam logic [STEP_W-1:0] ST_INT1 = 4'd7;
  localparam logic [STEP_W-1:0] ST_DLY  = 4'd8;
  localparam logic [STEP_W-1:0] ST_FB   = 4'd9;
  localparam logic [STEP_W-1:0] ST_WR   = 4'd10;
  localparam logic [STEP_W-1:0] ST_WET  = 4'd11;
  localparam logic [STEP_W-1:0] ST_OUT  = 4'd12;

  // Condition under which a step advances to its successor.
  typedef enum logic [1:0] {
    COND_GO,
    COND_IN,
    COND_OUT
  } cond_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    A_MAG,
    A_M0,
    A_M1,
    A_DLY,
    A_X
  } a_sel_t;

  typedef enum logic [2:0] {
    B_K,
    B_FINV,
    B_FRAC,
    B_FB,
    B_DRY,
    B_WET
  } b_sel_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // Register or memory that a step loads.
  typedef enum logic [3:0] {
    DST_NONE,
    DST_IN,
    DST_SD,
    DST_RP,
    DST_M0,
    DST_M1,
    DST_DLY,
    DST_MEM,
    DST_OUT
  } dst_t;

  // Memory read address select.
  typedef enum logic {
    RD_IDX0,
    RD_IDX1
  } rd_sel_t;

  // One control word of the program.
  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] nxt;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    dst_t              dst;
    rd_sel_t           rd_sel;
  } ucode_t;

  // Control word of the current step and whether it completes this cycle.
  typedef struct packed {
    ucode_t word;
    logic   adv;
  } step_ctl_t;

  // Status returned by the datapath to the sequencer.
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // Configuration registers.
  typedef struct packed {
    logic [31:0] delay_target;
    logic [15:0] feedback_gain;
    logic [15:0] wet_mix;
  } cfg_t;

  function automatic ucode_t mk(cond_t c, logic [STEP_W-1:0] n, a_sel_t a, b_sel_t b,
                                acc_op_t op, dst_t d, rd_sel_t r);
    ucode_t w;
    w.cond   = c;
    w.nxt    = n;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.dst    = d;
    w.rd_sel = r;
    return w;
  endfunction

  // The program: one sample per pass through steps ST_IN to ST_OUT.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      ST_IN:   w = mk(COND_IN,  ST_MULK, A_MAG, B_K,    ACC_NONE, DST_IN,   RD_IDX0);
      ST_MULK: w = mk(COND_GO,  ST_SD,   A_MAG, B_K,    ACC_LOAD, DST_NONE, RD_IDX0);
      ST_SD:   w = mk(COND_GO,  ST_RP,   A_MAG, B_K,    ACC_NONE, DST_SD,   RD_IDX0);
      ST_RP:   w = mk(COND_GO,  ST_RD0,  A_MAG, B_K,    ACC_NONE, DST_RP,   RD_IDX0);
      ST_RD0:  w = mk(COND_GO,  ST_RD1,  A_MAG, B_K,    ACC_NONE, DST_NONE, RD_IDX0);
      ST_RD1:  w = mk(COND_GO,  ST_INT0, A_MAG, B_K,    ACC_NONE, DST_M0,   RD_IDX1);
      ST_INT0: w = mk(COND_GO,  ST_INT1, A_M0,  B_FINV, ACC_LOAD, DST_M1,   RD_IDX1);
      ST_INT1: w = mk(COND_GO,  ST_DLY,  A_M1,  B_FRAC, ACC_ADD,  DST_NONE, RD_IDX0);
      ST_DLY:  w = mk(COND_GO,  ST_FB,   A_MAG, B_K,    ACC_NONE, DST_DLY,  RD_IDX0);
      ST_FB:   w = mk(COND_GO,  ST_WR,   A_DLY, B_FB,   ACC_LOAD, DST_NONE, RD_IDX0);
      ST_WR:   w = mk(COND_GO,  ST_WET,  A_X,   B_DRY,  ACC_LOAD, DST_MEM,  RD_IDX0);
      ST_WET:  w = mk(COND_GO,  ST_OUT,  A_DLY, B_WET,  ACC_ADD,  DST_NONE, RD_IDX0);
      ST_OUT:  w = mk(COND_OUT, ST_IN,   A_MAG, B_K,    ACC_NONE, DST_OUT,  RD_IDX0);
      default: w = mk(COND_GO,  ST_IN,   A_MAG, B_K,    ACC_NONE, DST_NONE, RD_IDX0);
    endcase
    return w;
  endfunction

endpackage

// File: sv/fdi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/fdi_seq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter and program table; each step waits on its condition and then
// jumps to the step that its control word names.
// ----------------------------------------------------------------------------
module fdi_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fdi_pkg::dp_stat_t stat,
  output fdi_pkg::step_ctl_t ctrl,
  output logic              in_ready
);
  import fdi_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            word;
  logic              adv;

  // Fetch the control word and evaluate its condition.
  always_comb begin
    word = ucode_rom(step_r);
    case (word.cond)
      COND_GO:  adv = 1'b1;
      COND_IN:  adv = in_valid;
      COND_OUT: adv = ~stat.out_busy;
      default:  adv = 1'b1;
    endcase
    step_nxt = adv ? word.nxt : step_r;
  end

  assign ctrl.word = word;
  assign ctrl.adv  = adv;
  assign in_ready  = (word.cond == COND_IN);

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IN;
    end else begin
      step_r <= step_nxt;
    end
  end

  // An accepted item starts the program.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (word.cond == COND_IN && in_valid) |=> (step_r == ST_MULK))
    else $error("accepted item did not start the program");

  // A stalled result holds the sequencer in the output step.
  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_OUT && stat.out_busy) |=> (step_r == ST_OUT))
    else $error("sequencer left the output step while the result was stalled");

endmodule

// File: sv/fdi_datapath.sv
// ----------------------------------------------------------------------------
// Feedback delay datapath
// Shared multiplier and accumulator, smoothed delay, read position logic,
// delay memory with fill tracking, and the output register.
// ----------------------------------------------------------------------------
module fdi_datapath #(
  parameter int BUFFER_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdi_pkg::step_ctl_t            ctrl,
  input  fdi_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output fdi_pkg::dp_stat_t             stat
);
  import fdi_pkg::*;

  localparam int AW = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = AW + 16;
  localparam int RW = (PW > 32 ? PW : 32) + 1;
  localparam longint unsigned LIMIT = longint'(BUFFER_DEPTH - 2) << 16;
  localparam longint unsigned SPAN  = longint'(BUFFER_DEPTH) << 16;
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] HALF15 = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] HALF16 = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF24 = ACC_W'(8388608);
  localparam logic signed [ACC_W-1:0] SMAX =
    (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  // Clamp to the signed sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  logic                          load;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          sign_r;
  logic [31:0]                   mag_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [31:0]                   sd_r;
  logic [AW-1:0]                 wp_r;
  logic                          wrapped_r;
  logic [AW-1:0]                 idx0_r;
  logic [AW-1:0]                 idx1_r;
  logic [15:0]                   frac_r;
  logic                          v0_r;
  logic                          v1_r;
  logic signed [SAMPLE_BITS-1:0] m0_r;
  logic signed [SAMPLE_BITS-1:0] m1_r;
  logic signed [SAMPLE_BITS-1:0] dly_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic [31:0]                   tgt;
  logic [32:0]                   diff;
  logic                          sign_nxt;
  logic [31:0]                   mag_nxt;
  logic [15:0]                   fb_sat;
  logic [15:0]                   wet_sat;
  logic [15:0]                   dry;
  logic [16:0]                   finv;
  logic signed [A_W-1:0]         mul_a;
  logic signed [B_W-1:0]         mul_b;
  logic signed [A_W+B_W-1:0]     prod;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       rnd15;
  logic signed [ACC_W-1:0]       rnd16;
  logic signed [ACC_W-1:0]       rnd24;
  logic [31:0]                   sd_nxt;
  logic signed [RW-1:0]          rp_diff;
  logic [RW-1:0]                 rp_wrap;
  logic [AW-1:0]                 idx0_nxt;
  logic [AW-1:0]                 idx1_nxt;
  logic signed [SAMPLE_BITS-1:0] stored;
  logic [AW-1:0]                 raddr;
  logic [SAMPLE_BITS-1:0]        rdata;

  assign load = ctrl.adv;

  // Clamped target and its distance from the smoothed delay.
  always_comb begin
    tgt      = (64'(cfg.delay_target) > LIMIT) ? 32'(LIMIT) : cfg.delay_target;
    diff     = {1'b0, tgt} - {1'b0, sd_r};
    sign_nxt = diff[32];
    mag_nxt  = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
  end

  // Saturated gains and interpolation weights.
  always_comb begin
    fb_sat  = (cfg.feedback_gain > UNITY_Q15) ? UNITY_Q15 : cfg.feedback_gain;
    wet_sat = (cfg.wet_mix > UNITY_Q15) ? UNITY_Q15 : cfg.wet_mix;
    dry     = UNITY_Q15 - wet_sat;
    finv    = 17'd65536 - {1'b0, frac_r};
  end

  // Shared multiplier and accumulator.
  always_comb begin
    case (ctrl.word.a_sel)
      A_MAG:   mul_a = $signed({1'b0, mag_r});
      A_M0:    mul_a = A_W'(m0_r);
      A_M1:    mul_a = A_W'(m1_r);
      A_DLY:   mul_a = A_W'(dly_r);
      A_X:     mul_a = A_W'(x_r);
      default: mul_a = '0;
    endcase
    case (ctrl.word.b_sel)
      B_K:     mul_b = B_W'(SMOOTH_K);
      B_FINV:  mul_b = $signed(B_W'(finv));
      B_FRAC:  mul_b = $signed(B_W'(frac_r));
      B_FB:    mul_b = $signed(B_W'(fb_sat));
      B_DRY:   mul_b = $signed(B_W'(dry));
      B_WET:   mul_b = $signed(B_W'(wet_sat));
      default: mul_b = '0;
    endcase
    prod = mul_a * mul_b;
    case (ctrl.word.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(prod);
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod);
      default:  acc_nxt = acc_r;
    endcase
  end

  // Round to nearest with halves upward.
  always_comb begin
    rnd15 = (acc_r + HALF15) >>> 15;
    rnd16 = (acc_r + HALF16) >>> 16;
    rnd24 = (acc_r + HALF24) >>> 24;
    sd_nxt = sign_r ? (sd_r - rnd24[31:0]) : (sd_r + rnd24[31:0]);
    stored = sat(ACC_W'(x_r) + rnd15);
  end

  // Read position behind the write position, wrapped into the buffer.
  always_comb begin
    rp_diff  = $signed(RW'({wp_r, 16'h0000})) - $signed(RW'(sd_r));
    rp_wrap  = rp_diff[RW-1] ? RW'(rp_diff + $signed(RW'(SPAN))) : RW'(rp_diff);
    idx0_nxt = rp_wrap[PW-1:16];
    idx1_nxt = (idx0_nxt == LAST_IDX) ? '0 : idx0_nxt + AW'(1);
  end

  // Delay memory; entries never written since reset read as zero.
  assign raddr = (ctrl.word.rd_sel == RD_IDX1) ? idx1_r : idx0_r;

  fdi_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(BUFFER_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (load && ctrl.word.dst == DST_MEM),
    .waddr(wp_r),
    .wdata(stored),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control state: smoothed delay, write position, fill mark, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r        <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load && ctrl.word.dst == DST_SD) begin
        sd_r <= sd_nxt;
      end
      if (load && ctrl.word.dst == DST_MEM) begin
        if (wp_r == LAST_IDX) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
      if (load && ctrl.word.dst == DST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (load) begin
      case (ctrl.word.dst)
        DST_IN: begin
          x_r    <= in_sample;
          sign_r <= sign_nxt;
          mag_r  <= mag_nxt;
        end
        DST_RP: begin
          idx0_r <= idx0_nxt;
          idx1_r <= idx1_nxt;
          frac_r <= rp_wrap[15:0];
          v0_r   <= wrapped_r || (idx0_nxt < wp_r);
          v1_r   <= wrapped_r || (idx1_nxt < wp_r);
        end
        DST_M0:  m0_r <= v0_r ? $signed(rdata) : '0;
        DST_M1:  m1_r <= v1_r ? $signed(rdata) : '0;
        DST_DLY: dly_r <= rnd16[SAMPLE_BITS-1:0];
        DST_OUT: out_sample_r <= sat(rnd15);
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign stat.out_busy = out_valid_r & ~out_ready;

  // The write position moves only with a memory write.
  a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(wp_r)) |-> $past(ctrl.adv && ctrl.word.dst == DST_MEM))
    else $error("write position moved without a memory write");

  // A result appears only after the output step.
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.adv && ctrl.word.dst == DST_OUT))
    else $error("result became valid outside the output step");

endmodule

// File: sv/feedback_delay_interpolated_top.sv
// ----------------------------------------------------------------------------
// Interpolating feedback delay
// Audio delay line with a smoothed fractional delay, linear interpolation,
// feedback into the delay memory and a dry/wet output mix.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready and mixed samples leave on
//   out_valid/out_ready, one result item for every input item. Registers
//   are written through cfg_valid/cfg_ready with cfg_index and cfg_data
//   (0: target delay Q16.16, 1: feedback gain Q1.15, 2: wet share Q1.15);
//   cfg_ready is always high, and writes belong in idle periods.
//   A microcode program of 13 steps runs once per item, and a new item is
//   taken only when the program is back in its first step. The step count is
//   set by the single shared multiplier (six products per item) and by the
//   two reads of the one memory read port. Reset clears the smoothed delay,
//   the write position and the registers but the wet share, which it sets to
//   one half; memory entries not yet written since reset read as zero via a
//   fill mark, so no clearing pass is needed and items are accepted at once.
//   If the receiver stalls, the finished result waits in the output register
//   while the next item is already accepted and processed; the program then
//   holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
module feedback_delay_interpolated_top #(
  parameter int BUFFER_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fdi_pkg::*;

  logic [31:0] delay_target_r;
  logic [15:0] feedback_gain_r;
  logic [15:0] wet_mix_r;
  cfg_t        cfg;
  step_ctl_t   ctrl;
  dp_stat_t    stat;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_target_r  <= '0;
      feedback_gain_r <= '0;
      wet_mix_r       <= WET_MIX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY_TARGET:  delay_target_r  <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[15:0];
        REG_WET_MIX:       wet_mix_r       <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.delay_target  = delay_target_r;
  assign cfg.feedback_gain = feedback_gain_r;
  assign cfg.wet_mix       = wet_mix_r;

  // Sequencer.
  fdi_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .stat    (stat),
    .ctrl    (ctrl),
    .in_ready(in_ready)
  );

  // Datapath and delay memory.
  fdi_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .in_sample (in_sample),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_sample(out_sample),
    .stat      (stat)
  );

endmodule

// File: dv/fdi_checker.sv
// ----------------------------------------------------------------------------
// Feedback delay checker
// Watches the configuration, sample and result channels of the interpolating
// feedback delay. It keeps its own copy of the delay memory, the smoothed delay
// and the registers, predicts the mixed sample of every accepted item and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module fdi_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [15:0]            in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [15:0]            out_sample,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  import fdi_pkg::*;

  localparam int          ADDR_W     = 16;
  localparam int          DEPTH      = 1 << ADDR_W;
  // Largest usable delay: depth minus two samples, in Q16.16.
  localparam logic [31:0] DELAY_CEIL = 32'hFFFE_0000;
  // Rounding offset of the Q0.24 smoothing product.
  localparam longint      STEP_HALF  = 64'sd1 << 23;
  localparam int          MAX_SHOWN  = 40;

  // Model state: delay memory, write position, smoothed delay and registers.
  logic signed [15:0] delay_mem [DEPTH];
  logic [ADDR_W-1:0]  wr_pos;
  logic [31:0]        smooth_dly;
  logic [31:0]        dly_target;
  logic [15:0]        fb_gain;
  logic [15:0]        wet_share;

  // Mixed samples predicted but not yet seen on the result channel.
  logic signed [15:0] expected_mix [$];

  // Divide by 2^n, rounding to nearest with halves going upwards.
  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Clamp to the signed 16-bit sample range.
  function automatic longint clip_sample(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the model by one input sample and return the mixed sample.
  function automatic logic signed [15:0] mix_next_sample(input logic signed [15:0] x);
    logic [31:0]       tgt;
    logic [31:0]       rpos;
    logic [ADDR_W-1:0] idx0;
    logic [ADDR_W-1:0] idx1;
    longint            diff;
    longint            mag;
    longint            stp;
    longint            frac;
    longint            near_v;
    longint            far_v;
    longint            dly;
    longint            fb;
    longint            wet;
    longint            xs;
    longint            stored;
    longint            mixed;

    // Move the smoothed delay one step toward the clamped target.
    tgt  = (dly_target > DELAY_CEIL) ? DELAY_CEIL : dly_target;
    diff = longint'({32'd0, tgt}) - longint'({32'd0, smooth_dly});
    mag  = ((diff < 0) ? -diff : diff) * SMOOTH_K;
    stp  = (mag + STEP_HALF) >>> 24;
    if (diff < 0) stp = -stp;
    smooth_dly = smooth_dly + stp[31:0];

    // Read the two neighbouring entries behind the write position.
    rpos   = {wr_pos, 16'd0} - smooth_dly;
    idx0   = rpos[31:16];
    idx1   = idx0 + 1'b1;
    frac   = rpos[15:0];
    near_v = delay_mem[idx0];
    far_v  = delay_mem[idx1];
    dly    = round_half_up((65536 - frac) * near_v + frac * far_v, 16);

    // Gains above unity are held at unity.
    fb  = (fb_gain > UNITY_Q15) ? UNITY_Q15 : fb_gain;
    wet = (wet_share > UNITY_Q15) ? UNITY_Q15 : wet_share;
    xs  = x;

    // Store the input plus feedback, then step the write position.
    stored            = clip_sample(xs + round_half_up(dly * fb, 15));
    delay_mem[wr_pos] = stored[15:0];
    wr_pos            = wr_pos + 1'b1;

    mixed = clip_sample(round_half_up(xs * (32768 - wet) + dly * wet, 15));
    return mixed[15:0];
  endfunction

  // Print one line for a failure and count it; later lines are suppressed.
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  // Follow the channels at every rising edge.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      foreach (delay_mem[i]) delay_mem[i] = '0;
      wr_pos     = '0;
      smooth_dly = '0;
      dly_target = '0;
      fb_gain    = '0;
      wet_share  = WET_MIX_RESET;
      expected_mix.delete();
    end else begin
      // Register writes; an unmapped index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY_TARGET:  dly_target = cfg_data;
          REG_FEEDBACK_GAIN: fb_gain    = cfg_data[15:0];
          REG_WET_MIX:       wet_share  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_mix.push_back(mix_next_sample(in_sample));
      // Compare each result with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending",
                                    out_sample));
        end else begin
          want = expected_mix.pop_front();
          checked++;
          if (out_sample !== want)
            report_mismatch($sformatf("result %0d: out_sample %0d, expected %0d",
                                      checked, out_sample, want));
        end
      end
    end
    pending = expected_mix.size();
  end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Feedback delay testbench
// Drives samples and register writes into the interpolating feedback delay
// with random gaps and output stalls. A short directed run covers extreme
// samples, zero delay from reset, unity and above-unity gains and a target
// beyond the memory; random settings and samples follow. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import fdi_pkg::*;

  localparam int                   CYCLE_LIMIT  = 1_000_000;
  localparam int                   RAND_PHASES  = 14;
  localparam int                   PHASE_ITEMS  = 100;
  localparam logic [31:0]          DELAY_CEIL   = 32'hFFFE_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [15:0]   in_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [15:0]   out_sample;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int chk_errors;
  int chk_pending;
  int chk_checked;
  int cycle_cnt = 0;
  int n_sent    = 0;
  int n_writes  = 0;
  int n_phases  = 0;
  bit steady    = 1'b0;

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feedback_delay_interpolated_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fdi_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (chk_errors),
    .pending    (chk_pending),
    .checked    (chk_checked)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Q1.15 gain: zero, unity, above unity or anything in range.
  function automatic logic [15:0] pick_q15();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'd0;
    if (r == 1) return UNITY_Q15;
    if (r == 2) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  // Offer one sample and hold it until the block takes it.
  task automatic push_sample(input logic signed [15:0] s);
    int g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Write one register through the configuration channel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    n_phases++;
  endtask

  // Receiver: ready in bursts with random stalls between them.
  initial begin : receiver
    int g;
    out_ready = 1'b0;
    forever begin
      g = steady ? 0 : pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, chk_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int                 ph;
    int                 k;
    int                 r;
    logic [31:0]        tgt;
    logic signed [15:0] s;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DELAY_TARGET;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero delay reads entries not yet written.
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    push_sample(16'sh3039);
    drain_results();

    // Short delay with unity feedback and a fully wet mix drives saturation.
    write_reg(REG_DELAY_TARGET, 32'h0002_8000);
    write_reg(REG_FEEDBACK_GAIN, {16'h0000, UNITY_Q15});
    write_reg(REG_WET_MIX, {16'hFFFF, UNITY_Q15});
    repeat (4) push_sample(16'sh7FFF);
    repeat (3) push_sample(16'sh8000);
    drain_results();

    // Target beyond the memory, gains above unity, and an unmapped index.
    write_reg(REG_DELAY_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_FEEDBACK_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_WET_MIX, 32'h0000_FFFF);
    write_reg(REG_UNMAPPED, 32'h0000_0000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'sh4000);
    push_sample(16'shC000);
    drain_results();

    // Random settings; the large targets come last so that the early phases
    // read back samples that have actually been written.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (ph == RAND_PHASES - 3)
        tgt = DELAY_CEIL;
      else if (ph == RAND_PHASES - 2)
        tgt = $urandom_range(32'hFFFF_FFFF, DELAY_CEIL + 1);
      else if (ph == RAND_PHASES - 1)
        tgt = $urandom;
      else if (ph == 3)
        tgt = '0;
      else
        tgt = {16'($urandom_range(0, 40)), 16'($urandom)};
      write_reg(REG_DELAY_TARGET, tgt);
      write_reg(REG_FEEDBACK_GAIN, {16'($urandom), pick_q15()});
      write_reg(REG_WET_MIX, {16'($urandom), pick_q15()});
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, $urandom);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else if (r == 1)
          s = 16'($signed($urandom_range(0, 128)) - 64);
        else
          s = 16'($urandom);
        push_sample(s);
      end
      drain_results();
    end
    steady = 1'b0;

    $display("Covered %0d samples over %0d register settings using %0d register writes.",
             n_sent, n_phases, n_writes);
    $display("Compared %0d mixed samples; %0d failures were counted.",
             chk_checked, chk_errors);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: feedback_delay_interpolated_top.f
sv/fdi_pkg.sv
sv/fdi_ram.sv
sv/fdi_seq.sv
sv/fdi_datapath.sv
sv/feedback_delay_interpolated_top.sv
dv/fdi_checker.sv
dv/tb.sv
